@@ src/mms_multipart_locator_top_macros.svh @@
// ----------------------------------------------------------------------------
// mms_multipart_locator_top_macros
// Assertion shorthands for the multipart locator: same-cycle and
// next-cycle implications, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef MMS_MULTIPART_LOCATOR_TOP_MACROS_SVH
`define MMS_MULTIPART_LOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define MML_ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error("mml assertion failed");

// next-cycle implication
`define MML_ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error("mml assertion failed");

`endif

@@ src/mml_pkg.sv @@
// ----------------------------------------------------------------------------
// mml_pkg
// Types and constants for the multipart message part locator.
// ----------------------------------------------------------------------------
`default_nettype none

package mml_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int OFFSET_BITS       = 24;
    localparam int SIZE_BITS         = 14;

    localparam logic [7:0] MAGIC_FIRST  = 8'h8c;
    localparam logic [7:0] MAGIC_SECOND = 8'h80;
    localparam logic [7:0] FLD_HEADEND  = 8'h84;
    localparam logic [7:0] FLD_LENVAL   = 8'h89;
    localparam logic [7:0] FLD_ARG      = 8'h81;
    localparam logic [7:0] FLD_NAME     = 8'h85;
    localparam logic [7:0] LOW7_MASK    = 8'h7f;
    localparam logic [7:0] LABEL_BASE   = 8'h41;

    typedef enum logic [1:0] {
        KIND_REJECT = 2'd0,
        KIND_NAME   = 2'd1,
        KIND_PART   = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_MAGIC  = 4'd0,
        PH_FIELD  = 4'd1,
        PH_SKIP84 = 4'd2,
        PH_LEN84  = 4'd3,
        PH_VAL84  = 4'd4,
        PH_COUNT  = 4'd5,
        PH_LEN89  = 4'd6,
        PH_VAL89  = 4'd7,
        PH_SHORT  = 4'd8,
        PH_STR    = 4'd9,
        PH_HSIZE  = 4'd10,
        PH_DSIZE1 = 4'd11,
        PH_DSIZE2 = 4'd12,
        PH_HDR    = 4'd13,
        PH_DATA   = 4'd14,
        PH_IDLE   = 4'd15
    } phase_t;

    typedef enum logic [2:0] {
        HS_CTLEN   = 3'd0,
        HS_CTFIRST = 3'd1,
        HS_CTSTR   = 3'd2,
        HS_CHK81   = 3'd3,
        HS_ARG81   = 3'd4,
        HS_CHK85   = 3'd5,
        HS_NAME    = 3'd6,
        HS_IGNORE  = 3'd7
    } hsub_t;

endpackage

`default_nettype wire

@@ src/mms_multipart_locator_top.sv @@
// A byte that fires a result loads the result register when it is accepted.
// One byte per cycle while item_ready is high; state steps once per byte.
// A result register decouples the sides; a new request is taken while the
// previous result waits, as long as the result register is free or drains.
// Reset (rst_n low, asynchronous) clears the parser to the magic check at
// position zero and empties the result register.
// ----------------------------------------------------------------------------
// mms_multipart_locator_top
// Streaming locator for the parts of a stored multipart message: checks the
// magic bytes, skips top-level fields, emits part names and part data spans.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mms_multipart_locator_top_macros.svh"

module mms_multipart_locator_top #(
    parameter int POSITION_BITS = mml_pkg::POSITION_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             item_valid,
    output logic                                  item_ready,
    input  wire logic [7:0]                       data_byte,
    input  wire logic                             file_start,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output logic [1:0]                            kind,
    output logic [7:0]                            name_char,
    output logic [7:0]                            part_label,
    output logic [mml_pkg::OFFSET_BITS-1:0]       data_offset,
    output logic [mml_pkg::SIZE_BITS-1:0]         data_size
);

    localparam int SB = mml_pkg::SIZE_BITS;
    localparam int OB = mml_pkg::OFFSET_BITS;

    mml_pkg::phase_t          phase_reg, phase_next, cur_phase;
    mml_pkg::hsub_t           hsub_reg, hsub_next, cur_hsub;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, cur_pos, pos_inc;
    logic [SB-1:0]            skip_reg, skip_next, cur_skip;
    logic [7:0]               parts_reg, parts_next, cur_parts;
    logic [7:0]               hsize_reg, hsize_next, cur_hsize;
    logic [7:0]               hleft_reg, hleft_next, cur_hleft;
    logic [6:0]               hibits_reg, hibits_next, cur_hibits;
    logic [SB-1:0]            dsize_reg, dsize_next, cur_dsize;

    logic                     item_accept;
    logic                     res_fire;
    logic                     locate;
    logic                     is_char;
    mml_pkg::kind_t           res_kind;
    logic [7:0]               res_char;
    logic [7:0]               res_label;
    logic [OB-1:0]            res_off;
    logic [SB-1:0]            res_size;
    logic [31:0]              off_wide;

    logic                     result_valid_reg;
    mml_pkg::kind_t           kind_reg;
    logic [7:0]               name_char_reg;
    logic [7:0]               part_label_reg;
    logic [OB-1:0]            data_offset_reg;
    logic [SB-1:0]            data_size_reg;

    assign item_ready  = !result_valid_reg || result_ready;
    assign item_accept = item_valid && item_ready;

    // restart the parser on the first byte of a file
    always_comb
    begin
        cur_phase  = file_start ? mml_pkg::PH_MAGIC : phase_reg;
        cur_hsub   = file_start ? mml_pkg::HS_CTLEN : hsub_reg;
        cur_pos    = file_start ? '0 : pos_reg;
        cur_skip   = file_start ? '0 : skip_reg;
        cur_parts  = file_start ? '0 : parts_reg;
        cur_hsize  = file_start ? '0 : hsize_reg;
        cur_hleft  = file_start ? '0 : hleft_reg;
        cur_hibits = file_start ? '0 : hibits_reg;
        cur_dsize  = file_start ? '0 : dsize_reg;
    end

    assign pos_inc  = cur_pos + POSITION_BITS'(1);
    assign off_wide = 32'(pos_inc);

    always_comb
    begin
        phase_next  = cur_phase;
        hsub_next   = cur_hsub;
        skip_next   = cur_skip;
        parts_next  = cur_parts;
        hsize_next  = cur_hsize;
        hleft_next  = cur_hleft;
        hibits_next = cur_hibits;
        dsize_next  = cur_dsize;
        pos_next    = pos_inc;
        res_fire    = 1'b0;
        locate      = 1'b0;
        is_char     = 1'b0;
        res_kind    = mml_pkg::KIND_REJECT;
        res_char    = '0;
        res_label   = '0;
        res_off     = '0;
        res_size    = '0;

        unique case (cur_phase)
            mml_pkg::PH_MAGIC:
            begin
                if (data_byte != ((cur_pos == '0) ? mml_pkg::MAGIC_FIRST
                                                  : mml_pkg::MAGIC_SECOND))
                begin
                    res_fire   = 1'b1;
                    phase_next = mml_pkg::PH_IDLE;
                end
                else if (cur_pos != '0)
                begin
                    phase_next = mml_pkg::PH_FIELD;
                end
            end
            mml_pkg::PH_FIELD:
            begin
                if (data_byte == mml_pkg::FLD_HEADEND)
                    phase_next = mml_pkg::PH_SKIP84;
                else if (data_byte == mml_pkg::FLD_LENVAL)
                    phase_next = mml_pkg::PH_LEN89;
                else if (data_byte[7])
                    phase_next = mml_pkg::PH_SHORT;
                else
                begin
                    parts_next = data_byte;
                    phase_next = (data_byte != '0) ? mml_pkg::PH_HSIZE : mml_pkg::PH_IDLE;
                end
            end
            mml_pkg::PH_SKIP84:
                phase_next = mml_pkg::PH_LEN84;
            mml_pkg::PH_LEN84:
            begin
                skip_next  = SB'(data_byte);
                phase_next = (data_byte != '0) ? mml_pkg::PH_VAL84 : mml_pkg::PH_COUNT;
            end
            mml_pkg::PH_VAL84:
            begin
                skip_next = cur_skip - SB'(1);
                if (skip_next == '0)
                    phase_next = mml_pkg::PH_COUNT;
            end
            mml_pkg::PH_COUNT:
            begin
                parts_next = data_byte;
                phase_next = (data_byte != '0) ? mml_pkg::PH_HSIZE : mml_pkg::PH_IDLE;
            end
            mml_pkg::PH_LEN89:
            begin
                skip_next  = SB'(data_byte);
                phase_next = (data_byte != '0) ? mml_pkg::PH_VAL89 : mml_pkg::PH_FIELD;
            end
            mml_pkg::PH_VAL89:
            begin
                skip_next = cur_skip - SB'(1);
                if (skip_next == '0)
                    phase_next = mml_pkg::PH_FIELD;
            end
            mml_pkg::PH_SHORT:
                phase_next = (data_byte[7] || data_byte == '0) ? mml_pkg::PH_FIELD
                                                               : mml_pkg::PH_STR;
            mml_pkg::PH_STR:
            begin
                if (data_byte == '0)
                    phase_next = mml_pkg::PH_FIELD;
            end
            mml_pkg::PH_HSIZE:
            begin
                parts_next = cur_parts - 8'd1;
                hsize_next = data_byte;
                phase_next = mml_pkg::PH_DSIZE1;
            end
            mml_pkg::PH_DSIZE1:
            begin
                if (data_byte[7])
                begin
                    hibits_next = data_byte[6:0];
                    phase_next  = mml_pkg::PH_DSIZE2;
                end
                else
                begin
                    dsize_next = SB'(data_byte);
                    if (cur_hsize == '0)
                        locate = 1'b1;
                    else
                    begin
                        hleft_next = cur_hsize;
                        hsub_next  = mml_pkg::HS_CTLEN;
                        phase_next = mml_pkg::PH_HDR;
                    end
                end
            end
            mml_pkg::PH_DSIZE2:
            begin
                dsize_next = {cur_hibits, data_byte[6:0]};
                if (cur_hsize == '0)
                    locate = 1'b1;
                else
                begin
                    hleft_next = cur_hsize;
                    hsub_next  = mml_pkg::HS_CTLEN;
                    phase_next = mml_pkg::PH_HDR;
                end
            end
            mml_pkg::PH_HDR:
            begin
                unique case (cur_hsub)
                    mml_pkg::HS_CTLEN:
                        hsub_next = (data_byte < cur_hsize) ? mml_pkg::HS_CTFIRST
                                                            : mml_pkg::HS_IGNORE;
                    mml_pkg::HS_CTFIRST:
                        hsub_next = (data_byte[7] || data_byte == '0) ? mml_pkg::HS_CHK81
                                                                      : mml_pkg::HS_CTSTR;
                    mml_pkg::HS_CTSTR:
                    begin
                        if (data_byte == '0)
                            hsub_next = mml_pkg::HS_CHK81;
                    end
                    mml_pkg::HS_CHK81:
                    begin
                        if (data_byte == mml_pkg::FLD_ARG)
                            hsub_next = mml_pkg::HS_ARG81;
                        else if (data_byte == mml_pkg::FLD_NAME)
                            hsub_next = mml_pkg::HS_NAME;
                        else
                            hsub_next = mml_pkg::HS_IGNORE;
                    end
                    mml_pkg::HS_ARG81:
                        hsub_next = mml_pkg::HS_CHK85;
                    mml_pkg::HS_CHK85:
                        hsub_next = (data_byte == mml_pkg::FLD_NAME) ? mml_pkg::HS_NAME
                                                                     : mml_pkg::HS_IGNORE;
                    mml_pkg::HS_NAME:
                    begin
                        if (data_byte == '0)
                            hsub_next = mml_pkg::HS_IGNORE;
                        else
                            is_char = 1'b1;
                    end
                    mml_pkg::HS_IGNORE:
                        hsub_next = cur_hsub;
                endcase
                hleft_next = cur_hleft - 8'd1;
                if (hleft_next == '0)
                    locate = 1'b1;
                else if (is_char)
                begin
                    res_fire = 1'b1;
                    res_kind = mml_pkg::KIND_NAME;
                    res_char = data_byte;
                end
            end
            mml_pkg::PH_DATA:
            begin
                skip_next = cur_skip - SB'(1);
                if (skip_next == '0)
                    phase_next = (cur_parts != '0) ? mml_pkg::PH_HSIZE : mml_pkg::PH_IDLE;
            end
            mml_pkg::PH_IDLE:
                phase_next = cur_phase;
        endcase

        if (locate)
        begin
            res_fire  = 1'b1;
            res_kind  = mml_pkg::KIND_PART;
            res_label = mml_pkg::LABEL_BASE + parts_next;
            res_off   = off_wide[OB-1:0];
            res_size  = dsize_next;
            skip_next = dsize_next;
            if (dsize_next != '0)
                phase_next = mml_pkg::PH_DATA;
            else
                phase_next = (parts_next != '0) ? mml_pkg::PH_HSIZE : mml_pkg::PH_IDLE;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mml_pkg::PH_MAGIC;
            hsub_reg   <= mml_pkg::HS_CTLEN;
            pos_reg    <= '0;
            skip_reg   <= '0;
            parts_reg  <= '0;
            hsize_reg  <= '0;
            hleft_reg  <= '0;
            hibits_reg <= '0;
            dsize_reg  <= '0;
        end
        else if (item_accept)
        begin
            phase_reg  <= phase_next;
            hsub_reg   <= hsub_next;
            pos_reg    <= pos_next;
            skip_reg   <= skip_next;
            parts_reg  <= parts_next;
            hsize_reg  <= hsize_next;
            hleft_reg  <= hleft_next;
            hibits_reg <= hibits_next;
            dsize_reg  <= dsize_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (item_accept && res_fire)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && res_fire)
        begin
            kind_reg        <= res_kind;
            name_char_reg   <= res_char;
            part_label_reg  <= res_label;
            data_offset_reg <= res_off;
            data_size_reg   <= res_size;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign name_char    = name_char_reg;
    assign part_label   = part_label_reg;
    assign data_offset  = data_offset_reg;
    assign data_size    = data_size_reg;

    `MML_ASSERT_IMP(a_data_nonzero, clk, rst_n, phase_reg == mml_pkg::PH_DATA, skip_reg != '0)
    `MML_ASSERT_IMP(a_hdr_left, clk, rst_n, phase_reg == mml_pkg::PH_HDR, hleft_reg != '0)
    `MML_ASSERT_IMP(a_name_clean, clk, rst_n, result_valid_reg && kind_reg == mml_pkg::KIND_NAME, part_label_reg == '0 && data_offset_reg == '0 && data_size_reg == '0)
    `MML_ASSERT_NXT(a_drain, clk, rst_n, result_valid_reg && result_ready && !item_accept, !result_valid_reg)

endmodule

`default_nettype wire
